@@ rtl/double_length_block_cipher_hash_defines.svh @@
// Assertion helpers used by the RTL.
`ifndef DOUBLE_LENGTH_BLOCK_CIPHER_HASH_DEFINES_SVH
`define DOUBLE_LENGTH_BLOCK_CIPHER_HASH_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset.
`define DLH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal is never high while reset is released.
`define DLH_NEVER(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

@@ rtl/dlh_pkg.sv @@
package dlh_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned LenW    = 6;
  localparam int unsigned NumRegs = 5;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned Rounds  = 32;
  localparam int unsigned RndW    = 5;
  localparam int unsigned QDepth  = 2;

  localparam logic [RegIdxW-1:0] RegIv0    = 3'd0;
  localparam logic [RegIdxW-1:0] RegIv1    = 3'd1;
  localparam logic [RegIdxW-1:0] RegIv2    = 3'd2;
  localparam logic [RegIdxW-1:0] RegIv3    = 3'd3;
  localparam logic [RegIdxW-1:0] RegHashLen = 3'd4;

  localparam logic [LenW-1:0] MaxLen = 6'd32;

  typedef struct packed {
    logic [WordW-1:0] block_hi;
    logic [WordW-1:0] block_lo;
    logic             first_block;
    logic             last_block;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] hash_word0;
    logic [WordW-1:0] hash_word1;
    logic [WordW-1:0] hash_word2;
    logic [WordW-1:0] hash_word3;
  } out_item_t;

  // Front-to-back job: data block plus the chaining source decision.
  typedef struct packed {
    logic [WordW-1:0] block_hi;
    logic [WordW-1:0] block_lo;
    logic             use_iv;
    logic             emit;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRun,
    BkDone
  } back_state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  function automatic logic [31:0] tau(input logic [31:0] x);
    tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // Round constant: byte j is (4*i+j)*7 mod 256.
  function automatic logic [31:0] round_const(input logic [RndW-1:0] i);
    logic [7:0] b;
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'(({3'd0, i} * 8'd4 + 8'(j)) * 8'd7);
      r = {r[23:0], b};
    end
    round_const = r;
  endfunction

endpackage

@@ rtl/double_length_block_cipher_hash.sv @@
// A pushed block is dispatched from the queue and runs 32 rounds, then finishes,
// waiting for a free result register only if it emits a hash. Only one block is in
// work at a time; two SM4 datapaths run both ciphers and key schedules side by side.
// A two-entry input queue takes pushes while a block is in work.
// Reset (rst_ni low, asynchronous) empties queue and result, zeroes chaining value,
// sets IV to zero and hash length to 32.
module double_length_block_cipher_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dlh_pkg::in_item_t  in_data_i,
  output logic               empty,
  input  logic               pop,
  output dlh_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import dlh_pkg::*;

  logic [WordW-1:0] iv0_q, iv1_q, iv2_q, iv3_q;
  logic [LenW-1:0]  len_q;
  logic             job_valid, job_take;
  job_t             job;

  // Configuration registers: hold until rewritten, drop writes beyond the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv0_q <= '0; iv1_q <= '0; iv2_q <= '0; iv3_q <= '0;
      len_q <= MaxLen;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIv0:     iv0_q <= cfg_data_i;
        RegIv1:     iv1_q <= cfg_data_i;
        RegIv2:     iv2_q <= cfg_data_i;
        RegIv3:     iv3_q <= cfg_data_i;
        RegHashLen: len_q <= cfg_data_i[LenW-1:0];
        default:    ;
      endcase
    end
  end

  // Front: queue each request with its chaining source.
  dlh_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_data_i,
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  // Back: both cipher passes, chaining update and hash output register.
  dlh_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .iv_i        ({iv0_q, iv1_q, iv2_q, iv3_q}),
    .hash_len_i  (len_q),
    .empty, .pop, .out_data_o
  );

endmodule

@@ rtl/dlh_front.sv @@
module dlh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dlh_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  input  logic              job_take_i,
  output dlh_pkg::job_t     job_o
);
  import dlh_pkg::*;

  // Two-entry queue of classified jobs.
  job_t             mem_q [QDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full        = (cnt_q == 2'(QDepth));
  assign do_push     = push && !full;
  assign job_valid_o = (cnt_q != 2'd0);
  assign do_pop      = job_valid_o && job_take_i;
  assign job_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= '{block_hi:    in_data_i.block_hi,
                           block_lo:    in_data_i.block_lo,
                           use_iv:      in_data_i.first_block,
                           emit:        in_data_i.last_block};
    end
  end

endmodule

@@ rtl/dlh_back.sv @@
`include "double_length_block_cipher_hash_defines.svh"
module dlh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_take_o,
  input  dlh_pkg::job_t       job_i,
  input  logic [255:0]        iv_i,
  input  logic [5:0]          hash_len_i,
  output logic                empty,
  input  logic                pop,
  output dlh_pkg::out_item_t  out_data_o
);
  import dlh_pkg::*;

  back_state_e     state_q, state_d;
  logic [RndW-1:0] rnd_q;
  logic [127:0]    k1_q, k2_q, x1_q, x2_q;
  logic [127:0]    blk_q;
  logic            emit_q;
  logic [255:0]    chain_q;
  out_item_t       res_q;
  logic            res_valid_q;
  logic            start, finish, res_load;
  logic [127:0]    k1_n, k2_n, x1_n, x2_n;
  logic [255:0]    h_src, chain_new;
  logic [127:0]    b1, b2;
  logic [255:0]    hash_w;
  logic [5:0]      len;
  logic [5:0]      a_cnt;

  // One SM4 round with inline key schedule.
  function automatic logic [255:0] sm4_round(input logic [127:0] k, input logic [127:0] x,
                                             input logic [RndW-1:0] r);
    logic [31:0] b, t, u;
    b = tau(k[95:64] ^ k[63:32] ^ k[31:0] ^ round_const(r));
    t = k[127:96] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
    u = tau(x[95:64] ^ x[63:32] ^ x[31:0] ^ t);
    u = x[127:96] ^ u ^ rotl(u, 2) ^ rotl(u, 10) ^ rotl(u, 18) ^ rotl(u, 24);
    sm4_round = {k[95:0], t, x[95:0], u};
  endfunction

  assign h_src = job_i.use_iv ? iv_i : chain_q;
  assign start = (state_q == BkIdle) && job_valid_i;
  assign finish = (state_q == BkDone) && (!emit_q || !res_valid_q || pop);
  assign job_take_o = start;
  assign res_load = finish && emit_q;

  assign {k1_n, x1_n} = sm4_round(k1_q, x1_q, rnd_q);
  assign {k2_n, x2_n} = sm4_round(k2_q, x2_q, rnd_q);

  // Ciphertext is the reversed word order, then fold in the block.
  assign b1 = {x1_q[31:0], x1_q[63:32], x1_q[95:64], x1_q[127:96]} ^ blk_q;
  assign b2 = {x2_q[31:0], x2_q[63:32], x2_q[95:64], x2_q[127:96]} ^ blk_q;
  assign chain_new = {b1[127:64], b2[63:0], b2[127:64], b1[63:0]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:  if (job_valid_i) state_d = BkRun;
      BkRun:   if (rnd_q == RndW'(Rounds - 1)) state_d = BkDone;
      BkDone:  if (finish) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    len   = (hash_len_i > MaxLen) ? MaxLen : hash_len_i;
    a_cnt = (len + 6'd1) >> 1;
    for (int i = 0; i < 32; i++) begin
      hash_w[255-8*i -: 8] = 8'h00;
      if (6'(i) < a_cnt) hash_w[255-8*i -: 8] = chain_new[255-8*i -: 8];
      else if (6'(i) < len)
        hash_w[255-8*i -: 8] = chain_new[255-8*(16+i-int'(a_cnt)) -: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      rnd_q       <= '0;
      res_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q <= state_d;
      if (start) rnd_q <= '0;
      else if (state_q == BkRun) rnd_q <= rnd_q + RndW'(1);
      if (finish) chain_q <= chain_new;
      if (res_load) res_valid_q <= 1'b1;
      else if (pop && res_valid_q) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      k1_q   <= {h_src[255:192] & {1'b0, 63'h7fffffffffffffff}, h_src[191:128]}
                ^ {FK0, FK1, FK2, FK3};
      k2_q   <= {h_src[127:64] | {1'b1, 63'd0}, h_src[63:0]} ^ {FK0, FK1, FK2, FK3};
      x1_q   <= {job_i.block_hi, job_i.block_lo};
      x2_q   <= {job_i.block_hi, job_i.block_lo};
      blk_q  <= {job_i.block_hi, job_i.block_lo};
      emit_q <= job_i.emit;
    end else if (state_q == BkRun) begin
      k1_q <= k1_n; x1_q <= x1_n;
      k2_q <= k2_n; x2_q <= x2_n;
    end
    if (res_load) res_q <= hash_w;
  end

  assign empty      = !res_valid_q;
  assign out_data_o = res_q;

  `DLH_NEVER(a_take_busy, clk_i, rst_ni, job_take_o && state_q != BkIdle, "take while busy")
  `DLH_ASSERT(a_run_len, clk_i, rst_ni, start |=> state_q == BkRun, "run did not start")
  `DLH_ASSERT(a_load_free, clk_i, rst_ni, res_load |-> (!res_valid_q || pop), "result overrun")

endmodule

@@ dv/double_length_block_cipher_hash_tb.sv @@
module double_length_block_cipher_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dlh_pkg::*;

  // Settle time after the last expected hash before touching registers or
  // ending the run: up to three blocks without last_block may still be queued
  // or in the rounds.
  localparam int unsigned SettleCycles = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_data_i;
  logic        empty;
  logic        pop;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  double_length_block_cipher_hash DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the block: IV, hash length and chaining value.
  logic [63:0] iv_mirror [4];
  logic [5:0]  len_mirror;
  logic [63:0] chain_mirror [4];

  out_item_t   hashes_due [$];
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Word substitution through the cipher S-box.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One SM4 encryption, key schedule run alongside the data rounds.
  function automatic logic [127:0] sm4_encrypt(input logic [63:0] kh, input logic [63:0] kl,
                                               input logic [63:0] ph, input logic [63:0] pl);
    logic [31:0] rk [4];
    logic [31:0] st [4];
    logic [31:0] b;
    logic [31:0] t;
    logic [31:0] rc;
    logic [7:0]  cb;
    rk[0] = kh[63:32] ^ 32'ha3b1bac6;
    rk[1] = kh[31:0]  ^ 32'h56aa3350;
    rk[2] = kl[63:32] ^ 32'h677d9197;
    rk[3] = kl[31:0]  ^ 32'hb27022dc;
    st[0] = ph[63:32];
    st[1] = ph[31:0];
    st[2] = pl[63:32];
    st[3] = pl[31:0];
    for (int i = 0; i < 32; i++) begin
      rc = '0;
      for (int j = 0; j < 4; j++) begin
        cb = 8'(((4 * i) + j) * 7);
        rc = {rc[23:0], cb};
      end
      b = sub_word(rk[1] ^ rk[2] ^ rk[3] ^ rc);
      t = rk[0] ^ b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
      rk[0] = rk[1]; rk[1] = rk[2]; rk[2] = rk[3]; rk[3] = t;
      b = sub_word(st[1] ^ st[2] ^ st[3] ^ t);
      t = st[0] ^ b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
          ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
      st[0] = st[1]; st[1] = st[2]; st[2] = st[3]; st[3] = t;
    end
    return {st[3], st[2], st[1], st[0]};
  endfunction

  // Advance the chaining value by one block; queue a hash on the last block.
  task automatic absorb_block(input in_item_t blk);
    logic [63:0]  h [4];
    logic [127:0] c1;
    logic [127:0] c2;
    logic [7:0]   hb [32];
    logic [255:0] flat;
    int unsigned  n;
    int unsigned  a;
    out_item_t    hash;
    for (int i = 0; i < 4; i++) h[i] = blk.first_block ? iv_mirror[i] : chain_mirror[i];
    c1 = sm4_encrypt({1'b0, h[0][62:0]}, h[1], blk.block_hi, blk.block_lo);
    c2 = sm4_encrypt({1'b1, h[2][62:0]}, h[3], blk.block_hi, blk.block_lo);
    c1 ^= {blk.block_hi, blk.block_lo};
    c2 ^= {blk.block_hi, blk.block_lo};
    // cross-swap the halves at byte 8
    chain_mirror[0] = c1[127:64];
    chain_mirror[1] = c2[63:0];
    chain_mirror[2] = c2[127:64];
    chain_mirror[3] = c1[63:0];
    if (!blk.last_block) return;
    n = (len_mirror > 32) ? 32 : len_mirror;
    a = (n + 1) / 2;
    flat = {chain_mirror[0], chain_mirror[1], chain_mirror[2], chain_mirror[3]};
    for (int i = 0; i < 32; i++) hb[i] = 8'h00;
    for (int i = 0; i < a; i++) hb[i] = flat[255 - 8 * i -: 8];
    for (int i = 0; i < n / 2; i++) hb[a + i] = flat[127 - 8 * i -: 8];
    for (int i = 0; i < 32; i++) flat[255 - 8 * i -: 8] = hb[i];
    hash.hash_word0 = flat[255:192];
    hash.hash_word1 = flat[191:128];
    hash.hash_word2 = flat[127:64];
    hash.hash_word3 = flat[63:0];
    hashes_due.push_back(hash);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // Send one request; hold push high afterwards so back-to-back requests stream.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic first, input logic last);
    in_item_t blk;
    blk = '{block_hi: hi, block_lo: lo, first_block: first, last_block: last};
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    push      <= 1'b1;
    in_data_i <= blk;
    do @(posedge clk_i); while (full);
    absorb_block(blk);
  endtask

  // Drop push and wait until every hash has come and the rounds have settled.
  task automatic drain;
    @(negedge clk_i);
    push <= 1'b0;
    while (hashes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegIv0, RegIv1, RegIv2, RegIv3: iv_mirror[idx] = val;
      RegHashLen: len_mirror = val[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_iv(input logic [63:0] w0, input logic [63:0] w1,
                        input logic [63:0] w2, input logic [63:0] w3);
    write_reg(RegIv0, w0);
    write_reg(RegIv1, w1);
    write_reg(RegIv2, w2);
    write_reg(RegIv3, w3);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Results: pop at random per the receiver idle rate, check on acceptance.
  always @(negedge clk_i) pop <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (hashes_due.size() == 0) begin
        report_mismatch("hash with none outstanding", out_data_o.hash_word0, '0);
      end else begin
        if (out_data_o.hash_word0 !== hashes_due[0].hash_word0)
          report_mismatch("hash_word0", out_data_o.hash_word0, hashes_due[0].hash_word0);
        if (out_data_o.hash_word1 !== hashes_due[0].hash_word1)
          report_mismatch("hash_word1", out_data_o.hash_word1, hashes_due[0].hash_word1);
        if (out_data_o.hash_word2 !== hashes_due[0].hash_word2)
          report_mismatch("hash_word2", out_data_o.hash_word2, hashes_due[0].hash_word2);
        if (out_data_o.hash_word3 !== hashes_due[0].hash_word3)
          report_mismatch("hash_word3", out_data_o.hash_word3, hashes_due[0].hash_word3);
        void'(hashes_due.pop_front());
      end
    end
  end

  // Chain from the zeroed state with no first block, reset IV and length.
  task automatic test_reset_defaults;
    send_block('0, '0, 1'b0, 1'b1);
    send_block('1, '1, 1'b0, 1'b0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b1);
    send_block('0, '1, 1'b1, 1'b1);
    drain();
  endtask

  // Hash lengths: zero, one, odd, even, full, and beyond 32.
  task automatic test_hash_lengths;
    logic [5:0] lens [7] = '{6'd0, 6'd1, 6'd15, 6'd16, 6'd32, 6'd33, 6'd63};
    foreach (lens[i]) begin
      write_reg(RegHashLen, {58'd0, lens[i]});
      send_block(rand_word(), rand_word(), 1'b1, 1'b0);
      send_block(rand_word(), rand_word(), 1'b0, 1'b1);
      drain();
    end
  endtask

  // IV extremes exercise the forced key bit on both halves.
  task automatic test_iv_extremes;
    set_iv('1, '1, '1, '1);
    write_reg(RegHashLen, 64'd32);
    send_block('1, '0, 1'b1, 1'b1);
    send_block('0, '1, 1'b1, 1'b1);
    drain();
    set_iv('0, '0, '0, '0);
    send_block('1, '1, 1'b1, 1'b1);
    send_block('0, '0, 1'b1, 1'b1);
    drain();
  endtask

  // Mostly well-formed messages of random content, some broken framing.
  task automatic run_messages(input int unsigned n_blocks, input int unsigned pause_at);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n_blocks) begin
      if (pause_at != 0 && sent >= pause_at) begin
        pause_at = 0;
        @(negedge clk_i);
        push <= 1'b0;
        while (hashes_due.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(9) == 0) begin
        send_block(rand_word(), rand_word(), 1'($urandom()), 1'($urandom()));
        sent++;
      end else begin
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++)
          send_block(rand_word(), rand_word(), i == 0, i == k - 1);
        sent += k;
      end
    end
  endtask

  task automatic test_random_phases;
    int unsigned tx_pct [3] = '{25, 76, 0};
    int unsigned rx_pct [3] = '{76, 25, 0};
    logic [63:0] lens [3] = '{64'd1, 64'd32, 64'd0};
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      set_iv(rand_word(), rand_word(), rand_word(), rand_word());
      write_reg(RegHashLen, 64'($urandom_range(32, 1)));
      run_messages(140, (p == 0) ? 60 : 0);
      drain();
      write_reg(RegHashLen, lens[p]);
      run_messages(140, 0);
      drain();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegIv0;
    cfg_data_i  = '0;
    mismatches  = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 76;
    for (int i = 0; i < 4; i++) begin
      iv_mirror[i]    = '0;
      chain_mirror[i] = '0;
    end
    len_mirror = 6'd32;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_hash_lengths();
    test_iv_extremes();
    test_random_phases();

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
